// ===== src/bqbp_pkg.sv =====
`timescale 1ns / 1ps

package bqbp_pkg;

  // Coefficients are signed Q2.x words of fixed width.
  localparam int COEF_BITS    = 24;
  localparam int REG_IDX_BITS = 3;

  // Step counter runs 0..4 inside one section: four multiplies, one trailing accumulate.
  localparam logic [2:0] CALC_LAST  = 3'd4;
  localparam logic [2:0] CALC_FIRST = 3'd1;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_FIRST_B0  = 3'd0,
    REG_FIRST_A1  = 3'd1,
    REG_FIRST_A2  = 3'd2,
    REG_SECOND_B0 = 3'd3,
    REG_SECOND_A1 = 3'd4,
    REG_SECOND_A2 = 3'd5
  } cfg_reg_t;

  // One term of the section sum.
  typedef enum logic [1:0] {
    TERM_B0 = 2'd0,
    TERM_B2 = 2'd1,
    TERM_A1 = 2'd2,
    TERM_A2 = 2'd3
  } term_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CALC = 2'd1,
    ST_SECT = 2'd2,
    ST_HOLD = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic acc_en;
    logic acc_first;
    logic acc_sub;
  } mac_ctrl_t;

  typedef struct packed {
    mac_ctrl_t mac;
    logic      sec;
    term_t     term;
    logic      take_mid;
    logic      take_final;
    logic      load_out;
  } seq_ctrl_t;

endpackage

// ===== src/bqbp_mac.sv =====
`timescale 1ns / 1ps

module bqbp_mac import bqbp_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                          clk,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] mul_a,
  input  logic signed [COEF_BITS-1:0]   mul_b,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;

  localparam logic signed [ACC_BITS-1:0] RND =
    {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] SAT_HI =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SAT_LO =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  acc_next;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic signed [ACC_BITS-1:0]  base;
  logic signed [ACC_BITS-1:0]  shifted;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctrl.acc_en) begin
      acc <= acc_next;
    end
  end

  // The rounding constant is loaded with the first term, so the final
  // shift needs no further add.
  always_comb begin
    prod_ext = {{2{prod[PROD_BITS-1]}}, prod};
    base     = ctrl.acc_first ? RND : acc;
    acc_next = ctrl.acc_sub ? (base - prod_ext) : (base + prod_ext);
    shifted  = acc >>> COEF_FRAC_BITS;
    if (shifted > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = shifted[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== src/bqbp_seq.sv =====
`timescale 1ns / 1ps

module bqbp_seq import bqbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      clear,
  input  logic      out_free,
  output seq_ctrl_t ctrl,
  output logic      busy
);

  seq_state_t state;
  seq_state_t state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic       sec;
  logic       sec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sec   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sec   <= sec_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sec_next   = sec;
    ctrl       = '0;
    ctrl.sec   = sec;
    ctrl.term  = term_t'(cnt[1:0]);
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CALC;
          cnt_next   = '0;
          sec_next   = 1'b0;
        end else if (clear) begin
          state_next = ST_HOLD;
        end
      end
      ST_CALC: begin
        // The accumulator takes the registered product of the step before.
        ctrl.mac.acc_en    = (cnt != 3'd0);
        ctrl.mac.acc_first = (cnt == CALC_FIRST);
        ctrl.mac.acc_sub   = (cnt != CALC_FIRST);
        cnt_next = cnt + 3'd1;
        if (cnt == CALC_LAST) begin
          state_next = ST_SECT;
        end
      end
      ST_SECT: begin
        if (!sec) begin
          ctrl.take_mid = 1'b1;
          sec_next      = 1'b1;
          cnt_next      = '0;
          state_next    = ST_CALC;
        end else begin
          ctrl.take_final = 1'b1;
          state_next      = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/cascaded_biquad_bandpass_unit.sv =====
`timescale 1ns / 1ps

// Two cascaded direct-form-I biquad bandpass sections sharing one multiplier.
// Input channel: in_valid/in_stall carry op and sample. op low filters the
// sample; op high clears all six history words and yields a zero result.
// Output channel: out_valid/out_stall carry filtered, held in an output
// register that stays stable while out_stall is high.
// Coefficients are written through wr_en/wr_index/wr_data (indexes 0..5:
// first b0, a1, a2, then second b0, a1, a2; other indexes are ignored).
// They should only change while no transaction is in flight.
// A filter transaction runs, for each section, four multiply steps plus one
// accumulate step and one result step through the single shared
// multiply-accumulate unit, then loads the output register once that is free;
// only then can the next transaction be accepted. A clear transaction goes
// straight to loading the output register.
// in_stall is high while a transaction is being computed or while its result
// waits for the output register to free up; a stalled receiver therefore
// holds off at most one further transaction.
// Synchronous reset zeroes coefficients and history and empties the output.
module cascaded_biquad_bandpass_unit import bqbp_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] filtered,
  input  logic                          wr_en,
  input  logic [REG_IDX_BITS-1:0]       wr_index,
  input  logic [COEF_BITS-1:0]          wr_data
);

  // Coefficient registers.
  logic signed [COEF_BITS-1:0] first_b0;
  logic signed [COEF_BITS-1:0] first_a1;
  logic signed [COEF_BITS-1:0] first_a2;
  logic signed [COEF_BITS-1:0] second_b0;
  logic signed [COEF_BITS-1:0] second_a1;
  logic signed [COEF_BITS-1:0] second_a2;

  // History of input, inter-section and output samples.
  logic signed [SAMPLE_BITS-1:0] in_hist_one;
  logic signed [SAMPLE_BITS-1:0] in_hist_two;
  logic signed [SAMPLE_BITS-1:0] mid_hist_one;
  logic signed [SAMPLE_BITS-1:0] mid_hist_two;
  logic signed [SAMPLE_BITS-1:0] out_hist_one;
  logic signed [SAMPLE_BITS-1:0] out_hist_two;

  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic signed [SAMPLE_BITS-1:0] mid_res;
  logic signed [SAMPLE_BITS-1:0] res;

  logic                          accept;
  logic                          out_free;
  logic                          busy;
  seq_ctrl_t                     ctrl;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [COEF_BITS-1:0]   mul_b;
  logic signed [SAMPLE_BITS-1:0] mac_result;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  bqbp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !op),
    .clear    (accept && op),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  // Operand selection for the current term of the current section. The
  // second section's feed-forward history is the first section's output.
  always_comb begin
    unique case (ctrl.term)
      TERM_B0: begin
        mul_b = ctrl.sec ? second_b0 : first_b0;
        mul_a = ctrl.sec ? mid_res : sample_reg;
      end
      TERM_B2: begin
        mul_b = ctrl.sec ? second_b0 : first_b0;
        mul_a = ctrl.sec ? mid_hist_two : in_hist_two;
      end
      TERM_A1: begin
        mul_b = ctrl.sec ? second_a1 : first_a1;
        mul_a = ctrl.sec ? out_hist_one : mid_hist_one;
      end
      TERM_A2: begin
        mul_b = ctrl.sec ? second_a2 : first_a2;
        mul_a = ctrl.sec ? out_hist_two : mid_hist_two;
      end
      default: begin
        mul_b = '0;
        mul_a = '0;
      end
    endcase
  end

  bqbp_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .ctrl   (ctrl.mac),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .result (mac_result)
  );

  // Coefficient writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_b0  <= '0;
      first_a1  <= '0;
      first_a2  <= '0;
      second_b0 <= '0;
      second_a1 <= '0;
      second_a2 <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FIRST_B0:  first_b0  <= wr_data;
        REG_FIRST_A1:  first_a1  <= wr_data;
        REG_FIRST_A2:  first_a2  <= wr_data;
        REG_SECOND_B0: second_b0 <= wr_data;
        REG_SECOND_A1: second_a1 <= wr_data;
        REG_SECOND_A2: second_a2 <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // History is cleared by reset or by a clear transaction, and shifts only
  // once the second section has produced its result.
  always_ff @(posedge clk) begin
    if (rst || (accept && op)) begin
      in_hist_one  <= '0;
      in_hist_two  <= '0;
      mid_hist_one <= '0;
      mid_hist_two <= '0;
      out_hist_one <= '0;
      out_hist_two <= '0;
    end else if (ctrl.take_final) begin
      in_hist_two  <= in_hist_one;
      in_hist_one  <= sample_reg;
      mid_hist_two <= mid_hist_one;
      mid_hist_one <= mid_res;
      out_hist_two <= out_hist_one;
      out_hist_one <= mac_result;
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg <= sample;
    end
    if (accept && op) begin
      res <= '0;
    end else if (ctrl.take_final) begin
      res <= mac_result;
    end
    if (ctrl.take_mid) begin
      mid_res <= mac_result;
    end
    if (ctrl.load_out) begin
      filtered <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
